// ----- design/assert_macros.svh -----
// Assertion macros used by the imu_accel_gyro_lerp_sync_unit design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/imu_sync_pkg.sv -----
package imu_sync_pkg;

	localparam int TIME_W = 32;
	localparam int AXIS_W = 16;
	localparam int AXES   = 3;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef axis_t [AXES-1:0] axes_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_OUT
	} state_t;

endpackage

// ----- design/imu_sync_ram.sv -----
module imu_sync_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/imu_sync_div.sv -----
module imu_sync_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [imu_sync_pkg::TIME_W-1:0]   num,
	input  logic [imu_sync_pkg::TIME_W-1:0]   den,
	output logic                              done,
	output logic [FRAC_BITS-1:0]              quot
);

	localparam int TW = imu_sync_pkg::TIME_W;
	localparam int NW = $clog2(FRAC_BITS + 1);

	logic [TW-1:0] rem_q;
	logic [TW-1:0] den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [NW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [TW:0] shifted;
	logic [TW:0] diff;
	logic ge;

	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[TW-1:0] : shifted[TW-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- design/imu_accel_gyro_lerp_sync_unit.sv -----
// Fuses a stream of timestamped accelerometer and gyroscope requests. Gyro requests that are
// not older than the held accel sample are written to a GYRO_DEPTH-entry buffer; others, and
// those arriving when the buffer is full, are dropped. An accel request with N buffered gyros
// produces N fused records in arrival order, each with the accel axes interpolated linearly
// to the gyro time, and the last one flagged by last_of_run. A record whose interpolation
// factor needs the bit-serial divider, which produces one quotient bit per cycle, passes
// through it; the factor is set directly when it is exactly 0 or 1. The axes then pass one at
// a time through a single multiplier, each in a multiply state and an add state. The input
// stalls until the last record of a run is taken.
`include "assert_macros.svh"

module imu_accel_gyro_lerp_sync_unit #(
	parameter int GYRO_DEPTH      = 16,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                is_accel,
	input  logic [31:0]         sample_time,
	input  logic signed [15:0]  axis_x,
	input  logic signed [15:0]  axis_y,
	input  logic signed [15:0]  axis_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         out_timestamp,
	output logic signed [15:0]  gyro_x,
	output logic signed [15:0]  gyro_y,
	output logic signed [15:0]  gyro_z,
	output logic signed [15:0]  accel_x,
	output logic signed [15:0]  accel_y,
	output logic signed [15:0]  accel_z,
	output logic                last_of_run
);

	localparam int TW   = imu_sync_pkg::TIME_W;
	localparam int AXW  = imu_sync_pkg::AXIS_W;
	localparam int NAX  = imu_sync_pkg::AXES;
	localparam int F    = ALPHA_FRAC_BITS;
	localparam int AW   = (GYRO_DEPTH > 1) ? $clog2(GYRO_DEPTH) : 1;
	localparam int CW   = $clog2(GYRO_DEPTH + 1);
	localparam int MW   = TW + NAX * AXW;
	localparam int PW   = AXW + 1 + F + 2;
	localparam logic signed [PW-1:0] HALF = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

	imu_sync_pkg::state_t state_q, state_d;

	logic                 held_accel_valid_q;
	logic [TW-1:0]        held_time_q;
	imu_sync_pkg::axes_t  held_axes_q;
	logic [TW-1:0]        new_time_q;
	imu_sync_pkg::axes_t  new_axes_q;
	logic [CW-1:0]        gyro_count_q;
	logic [CW-1:0]        idx_q;
	logic [1:0]           ax_q;
	logic [F:0]           alpha_q;
	logic signed [PW-1:0] prod_q;
	logic [TW-1:0]        out_time_q;
	imu_sync_pkg::axes_t  out_gyro_q;
	imu_sync_pkg::axes_t  out_accel_q;
	logic                 last_q;

	logic                 in_acc;
	logic                 keep;
	logic                 ram_re;
	logic [MW-1:0]        ram_rdata;
	logic [TW-1:0]        rd_time;
	logic                 zero_a;
	logic                 sat;
	logic                 need_div;
	logic [F:0]           alpha_c;
	logic                 div_start;
	logic                 div_done;
	logic [F-1:0]         div_quot;
	logic signed [AXW:0]  diff_s;
	logic signed [F+1:0]  alpha_s;
	logic signed [PW-1:0] rnd;

	assign in_stall = (state_q != imu_sync_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign keep     = !is_accel && held_accel_valid_q && (sample_time >= held_time_q)
		&& (gyro_count_q < CW'(GYRO_DEPTH));

	imu_sync_ram #(
		.WIDTH(MW),
		.DEPTH(GYRO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (in_acc && keep),
		.waddr(gyro_count_q[AW-1:0]),
		.wdata({sample_time, axis_z, axis_y, axis_x}),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_time  = ram_rdata[MW-1 -: TW];
	assign zero_a   = (new_time_q <= held_time_q) || (rd_time <= held_time_q);
	assign sat      = rd_time >= new_time_q;
	assign need_div = !zero_a && !sat;
	assign alpha_c  = zero_a ? '0 : {1'b1, {F{1'b0}}};

	imu_sync_div #(
		.FRAC_BITS(F)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (rd_time - held_time_q),
		.den   (new_time_q - held_time_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign diff_s  = $signed({new_axes_q[ax_q][AXW-1], new_axes_q[ax_q]})
		- $signed({held_axes_q[ax_q][AXW-1], held_axes_q[ax_q]});
	assign alpha_s = $signed({1'b0, alpha_q});
	assign rnd     = (prod_q + HALF) >>> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imu_sync_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		div_start = 1'b0;
		case (state_q)
			imu_sync_pkg::ST_IDLE: begin
				if (in_acc && is_accel && held_accel_valid_q && gyro_count_q != '0) begin
					state_d = imu_sync_pkg::ST_READ;
				end
			end
			imu_sync_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = imu_sync_pkg::ST_CALC;
			end
			imu_sync_pkg::ST_CALC: begin
				if (need_div) begin
					div_start = 1'b1;
					state_d   = imu_sync_pkg::ST_DIV;
				end else begin
					state_d = imu_sync_pkg::ST_MUL;
				end
			end
			imu_sync_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = imu_sync_pkg::ST_MUL;
				end
			end
			imu_sync_pkg::ST_MUL: begin
				state_d = imu_sync_pkg::ST_ADD;
			end
			imu_sync_pkg::ST_ADD: begin
				state_d = (ax_q == 2'(NAX - 1)) ? imu_sync_pkg::ST_OUT : imu_sync_pkg::ST_MUL;
			end
			imu_sync_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = last_q ? imu_sync_pkg::ST_IDLE : imu_sync_pkg::ST_READ;
				end
			end
			default: begin
				state_d = imu_sync_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_accel_valid_q <= 1'b0;
			held_time_q        <= '0;
			held_axes_q        <= '0;
			gyro_count_q       <= '0;
			idx_q              <= '0;
			ax_q               <= '0;
		end else begin
			case (state_q)
				imu_sync_pkg::ST_IDLE: begin
					if (in_acc && !is_accel && keep) begin
						gyro_count_q <= gyro_count_q + 1'b1;
					end else if (in_acc && is_accel) begin
						idx_q <= '0;
						if (!(held_accel_valid_q && gyro_count_q != '0)) begin
							held_accel_valid_q <= 1'b1;
							held_time_q        <= sample_time;
							held_axes_q        <= {axis_z, axis_y, axis_x};
							gyro_count_q       <= '0;
						end
					end
				end
				imu_sync_pkg::ST_CALC: begin
					ax_q <= '0;
				end
				imu_sync_pkg::ST_ADD: begin
					if (ax_q != 2'(NAX - 1)) begin
						ax_q <= ax_q + 1'b1;
					end
				end
				imu_sync_pkg::ST_OUT: begin
					if (!out_stall) begin
						if (last_q) begin
							held_time_q  <= new_time_q;
							held_axes_q  <= new_axes_q;
							gyro_count_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == imu_sync_pkg::ST_IDLE && in_acc && is_accel) begin
			new_time_q <= sample_time;
			new_axes_q <= {axis_z, axis_y, axis_x};
		end
		if (state_q == imu_sync_pkg::ST_CALC) begin
			out_time_q <= rd_time;
			out_gyro_q <= ram_rdata[NAX*AXW-1:0];
			last_q     <= (idx_q + 1'b1) == gyro_count_q;
			if (!need_div) begin
				alpha_q <= alpha_c;
			end
		end
		if (state_q == imu_sync_pkg::ST_DIV && div_done) begin
			alpha_q <= {1'b0, div_quot};
		end
		if (state_q == imu_sync_pkg::ST_MUL) begin
			prod_q <= diff_s * alpha_s;
		end
		if (state_q == imu_sync_pkg::ST_ADD) begin
			out_accel_q[ax_q] <= held_axes_q[ax_q] + rnd[AXW-1:0];
		end
	end

	assign out_valid     = (state_q == imu_sync_pkg::ST_OUT);
	assign out_timestamp = out_time_q;
	assign gyro_x        = out_gyro_q[0];
	assign gyro_y        = out_gyro_q[1];
	assign gyro_z        = out_gyro_q[2];
	assign accel_x       = out_accel_q[0];
	assign accel_y       = out_accel_q[1];
	assign accel_z       = out_accel_q[2];
	assign last_of_run   = last_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, gyro_count_q <= CW'(GYRO_DEPTH))
	`ASSERT_IMPLY(a_idle_no_out, clk, arst_n, !in_stall, !out_valid)
	`ASSERT_IMPLY(a_div_in_div, clk, arst_n, div_done, state_q == imu_sync_pkg::ST_DIV)
	`ASSERT_ALWAYS(a_held_kept, clk, arst_n, !$fell(held_accel_valid_q))
	`ASSERT_IMPLY(a_idx_range, clk, arst_n, in_stall, idx_q < gyro_count_q)

endmodule
